// File: hw/rtl/stt_pkg.sv
// Package: types, constants and character classes for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int unsigned OffsetBits = 32;
  localparam int unsigned LengthBits = 16;
  localparam int unsigned KindBits   = 6;
  localparam int unsigned MaxTokens  = 3;

  // Character constants
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChLt      = 8'h3C;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChBar     = 8'h7C;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChLBrack  = 8'h5B;
  localparam logic [7:0] ChRBrack  = 8'h5D;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChCaret   = 8'h5E;
  localparam logic [7:0] ChTilde   = 8'h7E;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChPercent = 8'h25;

  // Token kinds
  localparam logic [KindBits-1:0] KindLBrace  = 6'd0;
  localparam logic [KindBits-1:0] KindRBrace  = 6'd1;
  localparam logic [KindBits-1:0] KindLParen  = 6'd2;
  localparam logic [KindBits-1:0] KindRParen  = 6'd3;
  localparam logic [KindBits-1:0] KindLBrack  = 6'd4;
  localparam logic [KindBits-1:0] KindRBrack  = 6'd5;
  localparam logic [KindBits-1:0] KindSemi    = 6'd6;
  localparam logic [KindBits-1:0] KindColon   = 6'd7;
  localparam logic [KindBits-1:0] KindComma   = 6'd8;
  localparam logic [KindBits-1:0] KindLt      = 6'd9;
  localparam logic [KindBits-1:0] KindLe      = 6'd10;
  localparam logic [KindBits-1:0] KindShl     = 6'd11;
  localparam logic [KindBits-1:0] KindGt      = 6'd12;
  localparam logic [KindBits-1:0] KindGe      = 6'd13;
  localparam logic [KindBits-1:0] KindShr     = 6'd14;
  localparam logic [KindBits-1:0] KindAssign  = 6'd15;
  localparam logic [KindBits-1:0] KindEqEq    = 6'd16;
  localparam logic [KindBits-1:0] KindNot     = 6'd17;
  localparam logic [KindBits-1:0] KindNe      = 6'd18;
  localparam logic [KindBits-1:0] KindAmp     = 6'd19;
  localparam logic [KindBits-1:0] KindAndAnd  = 6'd20;
  localparam logic [KindBits-1:0] KindBar     = 6'd21;
  localparam logic [KindBits-1:0] KindOrOr    = 6'd22;
  localparam logic [KindBits-1:0] KindCaret   = 6'd23;
  localparam logic [KindBits-1:0] KindTilde   = 6'd24;
  localparam logic [KindBits-1:0] KindPlus    = 6'd25;
  localparam logic [KindBits-1:0] KindStar    = 6'd26;
  localparam logic [KindBits-1:0] KindMinus   = 6'd27;
  localparam logic [KindBits-1:0] KindArrow   = 6'd28;
  localparam logic [KindBits-1:0] KindSlash   = 6'd29;
  localparam logic [KindBits-1:0] KindPercent = 6'd30;
  localparam logic [KindBits-1:0] KindIdent   = 6'd31;
  localparam logic [KindBits-1:0] KindInt     = 6'd32;
  localparam logic [KindBits-1:0] KindError   = 6'd33;
  localparam logic [KindBits-1:0] KindEnd     = 6'd34;
  localparam logic [KindBits-1:0] KindNone    = 6'd63;

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModePend    = 3'd1,
    ModeIdent   = 3'd2,
    ModeInt     = 3'd3,
    ModeComment = 3'd4
  } mode_e;

  typedef struct packed {
    logic [KindBits-1:0]   kind;
    logic [OffsetBits-1:0] start;
    logic [LengthBits-1:0] len;
    logic                  last;
  } token_t;

  // Tokens produced by one byte, slot 0 first
  typedef struct packed {
    logic [1:0]                 cnt;
    token_t [MaxTokens-1:0]     tok;
  } step_t;

  function automatic logic [KindBits-1:0] single_kind(logic [7:0] c);
    logic [KindBits-1:0] k;
    case (c)
      ChLBrace:  k = KindLBrace;
      ChRBrace:  k = KindRBrace;
      ChLParen:  k = KindLParen;
      ChRParen:  k = KindRParen;
      ChLBrack:  k = KindLBrack;
      ChRBrack:  k = KindRBrack;
      ChSemi:    k = KindSemi;
      ChColon:   k = KindColon;
      ChComma:   k = KindComma;
      ChLt:      k = KindLt;
      ChGt:      k = KindGt;
      ChEq:      k = KindAssign;
      ChBang:    k = KindNot;
      ChAmp:     k = KindAmp;
      ChBar:     k = KindBar;
      ChCaret:   k = KindCaret;
      ChTilde:   k = KindTilde;
      ChPlus:    k = KindPlus;
      ChStar:    k = KindStar;
      ChMinus:   k = KindMinus;
      ChSlash:   k = KindSlash;
      ChPercent: k = KindPercent;
      default:   k = KindNone;
    endcase
    return k;
  endfunction

  function automatic logic [KindBits-1:0] pair_kind(logic [7:0] p, logic [7:0] c);
    logic [KindBits-1:0] k;
    k = KindNone;
    if (p == ChLt && c == ChEq) k = KindLe;
    else if (p == ChLt && c == ChLt) k = KindShl;
    else if (p == ChGt && c == ChEq) k = KindGe;
    else if (p == ChGt && c == ChGt) k = KindShr;
    else if (p == ChEq && c == ChEq) k = KindEqEq;
    else if (p == ChBang && c == ChEq) k = KindNe;
    else if (p == ChAmp && c == ChAmp) k = KindAndAnd;
    else if (p == ChBar && c == ChBar) k = KindOrOr;
    else if (p == ChMinus && c == ChGt) k = KindArrow;
    return k;
  endfunction

  function automatic logic starts_pair(logic [7:0] c);
    return c == ChLt || c == ChGt || c == ChEq || c == ChBang ||
           c == ChAmp || c == ChBar || c == ChMinus || c == ChSlash;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_ident_start(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChNewline;
  endfunction

endpackage

// File: hw/rtl/stt_scan.sv
// Scanner state and per-byte next-state / token logic.
`timescale 1ns / 1ps

module stt_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      char_i,
  input  logic            eoi_i,
  output stt_pkg::step_t  step_o
);

  stt_pkg::mode_e                   mode_q, mode_d;
  logic [7:0]                       pend_q, pend_d;
  logic [stt_pkg::OffsetBits-1:0]   start_q, start_d;
  logic [stt_pkg::LengthBits-1:0]   len_q, len_d;
  logic [stt_pkg::OffsetBits-1:0]   off_q, off_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stt_pkg::ModeIdle;
      pend_q  <= '0;
      start_q <= '0;
      len_q   <= '0;
      off_q   <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      start_q <= start_d;
      len_q   <= len_d;
      off_q   <= off_d;
    end
  end

  always_comb begin
    logic                          used;
    logic [1:0]                    n;
    logic [stt_pkg::KindBits-1:0]  pk;
    logic [stt_pkg::KindBits-1:0]  sk;

    used    = 1'b0;
    n       = '0;
    mode_d  = mode_q;
    pend_d  = pend_q;
    start_d = start_q;
    len_d   = len_q;
    step_o  = '0;
    pk      = stt_pkg::pair_kind(pend_q, char_i);
    sk      = stt_pkg::single_kind(char_i);

    case (mode_q)
      stt_pkg::ModePend: begin
        if (pend_q == stt_pkg::ChSlash && char_i == stt_pkg::ChSlash) begin
          mode_d = stt_pkg::ModeComment;
          used   = 1'b1;
        end else if (pk != stt_pkg::KindNone) begin
          step_o.tok[n] = '{pk, start_q, stt_pkg::LengthBits'(2), 1'b0};
          n      = n + 2'd1;
          mode_d = stt_pkg::ModeIdle;
          used   = 1'b1;
        end else begin
          step_o.tok[n] = '{stt_pkg::single_kind(pend_q), start_q,
                            stt_pkg::LengthBits'(1), 1'b0};
          n      = n + 2'd1;
          mode_d = stt_pkg::ModeIdle;
        end
      end
      stt_pkg::ModeIdent, stt_pkg::ModeInt: begin
        if (stt_pkg::is_digit(char_i) ||
            (mode_q == stt_pkg::ModeIdent && stt_pkg::is_ident_start(char_i))) begin
          if (len_q != '1) len_d = len_q + 1'b1;
          used = 1'b1;
        end else begin
          step_o.tok[n] = '{(mode_q == stt_pkg::ModeIdent) ? stt_pkg::KindIdent
                                                            : stt_pkg::KindInt,
                            start_q, len_q, 1'b0};
          n      = n + 2'd1;
          mode_d = stt_pkg::ModeIdle;
        end
      end
      stt_pkg::ModeComment: begin
        if (char_i == stt_pkg::ChNewline) mode_d = stt_pkg::ModeIdle;
        used = 1'b1;
      end
      default: mode_d = stt_pkg::ModeIdle;
    endcase

    if (!used) begin
      if (stt_pkg::is_blank(char_i)) begin
        // skipped
      end else if (stt_pkg::starts_pair(char_i)) begin
        mode_d  = stt_pkg::ModePend;
        pend_d  = char_i;
        start_d = off_q;
      end else if (sk != stt_pkg::KindNone) begin
        step_o.tok[n] = '{sk, off_q, stt_pkg::LengthBits'(1), 1'b0};
        n = n + 2'd1;
      end else if (stt_pkg::is_ident_start(char_i) || stt_pkg::is_digit(char_i)) begin
        mode_d  = stt_pkg::is_digit(char_i) ? stt_pkg::ModeInt : stt_pkg::ModeIdent;
        start_d = off_q;
        len_d   = stt_pkg::LengthBits'(1);
      end else begin
        step_o.tok[n] = '{stt_pkg::KindError, off_q, stt_pkg::LengthBits'(1), 1'b0};
        n = n + 2'd1;
      end
    end

    off_d = off_q + 1'b1;

    if (eoi_i) begin
      case (mode_d)
        stt_pkg::ModePend: begin
          step_o.tok[n] = '{stt_pkg::single_kind(pend_d), start_d,
                            stt_pkg::LengthBits'(1), 1'b0};
          n = n + 2'd1;
        end
        stt_pkg::ModeIdent: begin
          step_o.tok[n] = '{stt_pkg::KindIdent, start_d, len_d, 1'b0};
          n = n + 2'd1;
        end
        stt_pkg::ModeInt: begin
          step_o.tok[n] = '{stt_pkg::KindInt, start_d, len_d, 1'b0};
          n = n + 2'd1;
        end
        default: ;
      endcase
      step_o.tok[n] = '{stt_pkg::KindEnd, off_d, '0, 1'b0};
      n       = n + 2'd1;
      mode_d  = stt_pkg::ModeIdle;
      pend_d  = '0;
      start_d = '0;
      len_d   = '0;
      off_d   = '0;
    end

    if (n != 2'd0) step_o.tok[n - 2'd1].last = 1'b1;
    step_o.cnt = n;
  end

endmodule

// File: hw/rtl/stt_out_bank.sv
// Result register bank: holds the tokens of one byte and hands them out in order.
`timescale 1ns / 1ps

module stt_out_bank (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  stt_pkg::step_t  step_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            take_i,
  output stt_pkg::token_t tok_o
);

  stt_pkg::token_t [stt_pkg::MaxTokens-1:0] slot_q;
  logic [1:0]                               cnt_q, cnt_d;
  logic [1:0]                               head_q, head_d;

  assign valid_o = cnt_q != 2'd0;
  assign ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take_i);
  assign tok_o   = slot_q[head_q];

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    if (load_i) begin
      cnt_d  = step_i.cnt;
      head_d = '0;
    end else if (valid_o && take_i) begin
      cnt_d  = cnt_q - 2'd1;
      head_d = head_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) slot_q <= step_i.tok;
  end

endmodule

// File: hw/rtl/source_text_tokenizer.sv
// Top level of the source text tokenizer.
//
// Input stream: one source byte per transfer on s_axis; s_axis_tlast marks the
// final byte of a buffer. Output stream: one token per transfer on m_axis with
// the kind in m_axis_tuser, offset and length in m_axis_tdata, and
// m_axis_tlast on the final token caused by a given byte.
// A byte is held in an input register and scanned once the result bank can
// take it; its tokens (zero to three) are written into a three-entry result
// bank that drives m_axis, which offers a byte's first token after the bank
// is loaded. Throughput is one byte per cycle while each byte gives at most
// one token and m_axis_tready is high; a byte giving more tokens holds the
// bank until they are taken, since the bank drains one token per ready cycle.
// After the last byte of a buffer any open token is flushed, an end token is
// sent, and offsets restart at zero. A stalled receiver holds the bank, then
// the input register, then s_axis_tready drops; nothing is lost.
// Reset clears the scanner state, the input register's valid flag and the result bank's count.
`timescale 1ns / 1ps

module source_text_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] start_offset, [47:32] token_length
  output logic [5:0]  m_axis_tuser,   // [5:0] token_kind
  output logic        m_axis_tlast    // last_of_run
);

  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_char_q;
  logic            in_eoi_q;
  logic            bank_ready;
  logic            step_fire;
  stt_pkg::step_t  step;
  stt_pkg::token_t tok;

  assign step_fire     = in_valid_q && bank_ready;
  assign s_axis_tready = !in_valid_q || step_fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) in_valid_d = 1'b1;
    else if (step_fire)                 in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else         in_valid_q <= in_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tlast;
    end
  end

  stt_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (step_fire),
    .char_i (in_char_q),
    .eoi_i  (in_eoi_q),
    .step_o (step)
  );

  stt_out_bank u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step_fire),
    .step_i  (step),
    .ready_o (bank_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .tok_o   (tok)
  );

  assign m_axis_tdata = {tok.len, tok.start};
  assign m_axis_tuser = tok.kind;
  assign m_axis_tlast = tok.last;

endmodule

// File: hw/rtl/stt_checker.sv
// Port-level checker for the source text tokenizer, bound to the top level.
`timescale 1ns / 1ps

module stt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [5:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled token stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("token dropped while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= stt_pkg::KindEnd)
    else $error("token kind out of range");

  // End token closes the run and carries no length
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == stt_pkg::KindEnd |->
      m_axis_tlast && m_axis_tdata[47:32] == 16'd0)
    else $error("malformed end token");

  // Plain punctuators are one byte long
  a_punct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser <= stt_pkg::KindComma |->
      m_axis_tdata[47:32] == 16'd1)
    else $error("punctuator length not one");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
